// ===== src/phj_pkg.sv =====
// Shared constants and types for the pairwise Hamming / Jaccard distance block.
// No dependencies; every other file in src except phj_ram imports this package.
package phj_pkg;

  // Default sizing for the top-level parameters
  localparam int MAX_ROWS_DEF    = 64;
  localparam int MAX_COLUMNS_DEF = 256;
  localparam int ALLELE_BITS_DEF = 8;

  // Fixed field widths of the ports
  localparam int ROW_W      = 6;
  localparam int COLUMN_W   = 8;
  localparam int CODE_W     = 8;
  localparam int HAMMING_W  = 9;
  localparam int JAC_W      = 17;
  localparam int ROW_CNT_W  = 7;
  localparam int COL_CNT_W  = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Saturation limit of the Hamming field
  localparam int HAMMING_MAX = (1 << HAMMING_W) - 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd1;

  // Input actions
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_SWEEP = 1'b1;

  // Sweep sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_DIV_START,
    ST_DIV,
    ST_EMIT
  } phj_state_e;

endpackage

// ===== src/phj_ram.sv =====
// Generic simple RAM: one write port and two registered read ports sharing an enable.
// Depends on nothing; used for the allele matrix store.
module phj_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one cell
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register both read words
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// ===== src/phj_pair.sv =====
// Per-pair accumulator: counts differing columns, union and intersection of presence.
// Depends on phj_pkg; fed by the registered read words of phj_ram.
module phj_pair #(
  parameter int ALLELE_BITS = phj_pkg::ALLELE_BITS_DEF,
  parameter int CNT_W       = 9
) (
  input  logic                   clk_i,
  input  logic                   clear_i,
  input  logic                   valid_i,
  input  logic [ALLELE_BITS-1:0] a_i,
  input  logic [ALLELE_BITS-1:0] b_i,
  output logic [CNT_W-1:0]       ham_o,
  output logic [CNT_W-1:0]       uni_o,
  output logic [CNT_W-1:0]       inter_o
);

  import phj_pkg::*;

  localparam logic [ALLELE_BITS-1:0] PRESENT = ALLELE_BITS'(1);

  logic [CNT_W-1:0] ham_q, uni_q, inter_q;
  logic             a_pres, b_pres;

  assign a_pres = (a_i == PRESENT);
  assign b_pres = (b_i == PRESENT);

  // Clear at pair start, then add one column per valid word
  always_ff @(posedge clk_i) begin
    if (clear_i) begin
      ham_q   <= '0;
      uni_q   <= '0;
      inter_q <= '0;
    end else if (valid_i) begin
      ham_q   <= ham_q + CNT_W'(a_i != b_i);
      uni_q   <= uni_q + CNT_W'(a_pres || b_pres);
      inter_q <= inter_q + CNT_W'(a_pres && b_pres);
    end
  end

  assign ham_o   = ham_q;
  assign uni_o   = uni_q;
  assign inter_o = inter_q;

endmodule

// ===== src/phj_div.sv =====
// Restoring divider: floor(num * 65536 / den) for num <= den, one quotient bit a cycle.
// Depends on phj_pkg.
module phj_div #(
  parameter int CNT_W = 9
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [CNT_W-1:0]         num_i,
  input  logic [CNT_W-1:0]         den_i,
  output logic                     busy_o,
  output logic [phj_pkg::JAC_W-1:0] quot_o
);

  import phj_pkg::*;

  localparam int STEP_W = $clog2(JAC_W);

  logic              busy_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W:0]    rem_q, trial, rem_next;
  logic [CNT_W-1:0]  den_q;
  logic [JAC_W-1:0]  quot_q;
  logic              ge;

  // First step compares the numerator itself, later steps shift in a zero
  always_comb begin
    trial    = (step_q == '0) ? rem_q : {rem_q[CNT_W-1:0], 1'b0};
    ge       = (trial >= {1'b0, den_q});
    rem_next = ge ? (trial - {1'b0, den_q}) : trial;
  end

  // Sequence the steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == STEP_W'(JAC_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Hold remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, num_i};
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_next;
      quot_q <= {quot_q[JAC_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

// ===== src/pairwise_hamming_jaccard_top.sv =====
// Pairwise Hamming / Jaccard block: matrix store, sweep sequencer and output register.
// A write word is accepted only in ST_IDLE. A sweep of row i runs its (rows-1-i) pairs in turn:
// per pair, the column reads, a drain, a divider start, the divider steps, a check that the divider
// is done and an emit (no drain when cols is 0); an output stall holds the emit.
// The next pair starts while a result waits in the output register. Reset clears both
// registers and the control state; the matrix store holds garbage until written.
module pairwise_hamming_jaccard_top #(
  parameter int MAX_ROWS    = phj_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = phj_pkg::MAX_COLUMNS_DEF,
  parameter int ALLELE_BITS = phj_pkg::ALLELE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [phj_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [phj_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           action_i,
  input  logic [phj_pkg::ROW_W-1:0]      row_index_i,
  input  logic [phj_pkg::COLUMN_W-1:0]   column_index_i,
  input  logic [phj_pkg::CODE_W-1:0]     allele_code_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [phj_pkg::ROW_W-1:0]      first_row_o,
  output logic [phj_pkg::ROW_W-1:0]      second_row_o,
  output logic [phj_pkg::HAMMING_W-1:0]  hamming_count_o,
  output logic [phj_pkg::JAC_W-1:0]      jaccard_q16_o,
  output logic                           last_of_sweep_o
);

  import phj_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CNTW  = $clog2(MAX_COLUMNS + 1);

  phj_state_e state_q, state_d;

  logic [ROW_CNT_W-1:0] row_count_q;
  logic [COL_CNT_W-1:0] col_count_q;
  logic [RCW-1:0]       rows_eff;
  logic [CNTW-1:0]      cols_eff;

  logic [RW-1:0]   i_q, i_d, j_q, j_d;
  logic [CNTW-1:0] l_q, l_d;
  logic            rd_vld_q;

  logic            in_acc, out_free, sweep_empty, pair_last;
  logic            row_ok, col_ok;
  logic            mem_we, rd_en, acc_clr, div_start, load_out;

  logic [AW-1:0]          waddr, raddr_a, raddr_b;
  logic [ALLELE_BITS-1:0] rdata_a, rdata_b;
  logic [CNTW-1:0]        ham, uni, inter;
  logic                   div_busy;
  logic [JAC_W-1:0]       quot;

  logic                 out_valid_q;
  logic [ROW_W-1:0]     first_row_q, second_row_q;
  logic [HAMMING_W-1:0] ham_out_q;
  logic [JAC_W-1:0]     jac_out_q;
  logic                 last_q;

  // Configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= '0;
      col_count_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ROW_COUNT:    row_count_q <= cfg_data_i[ROW_CNT_W-1:0];
        CFG_COLUMN_COUNT: col_count_q <= cfg_data_i[COL_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the counts at the store size
  assign rows_eff = (32'(row_count_q) > MAX_ROWS)    ? RCW'(MAX_ROWS)    : RCW'(row_count_q);
  assign cols_eff = (32'(col_count_q) > MAX_COLUMNS) ? CNTW'(MAX_COLUMNS) : CNTW'(col_count_q);

  // Handshake and item decode
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign sweep_empty = ((32'(row_index_i) + 1) >= 32'(rows_eff));
  assign pair_last   = ((32'(j_q) + 1) == 32'(rows_eff));
  assign row_ok      = (32'(row_index_i) < MAX_ROWS);
  assign col_ok      = (32'(column_index_i) < MAX_COLUMNS);

  // Store addresses: row times column pitch plus column
  assign waddr   = AW'(32'(row_index_i) * MAX_COLUMNS + 32'(column_index_i));
  assign raddr_a = AW'(32'(i_q) * MAX_COLUMNS + 32'(l_q[CW-1:0]));
  assign raddr_b = AW'(32'(j_q) * MAX_COLUMNS + 32'(l_q[CW-1:0]));

  // Next state and sequencer outputs
  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    l_d       = l_q;
    mem_we    = 1'b0;
    rd_en     = 1'b0;
    acc_clr   = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (action_i == ACT_WRITE) begin
            mem_we = row_ok && col_ok;
          end else if (!sweep_empty) begin
            i_d     = RW'(row_index_i);
            j_d     = RW'(32'(row_index_i) + 1);
            l_d     = '0;
            acc_clr = 1'b1;
            state_d = (cols_eff == '0) ? ST_DIV_START : ST_READ;
          end
        end
      end
      ST_READ: begin
        rd_en = 1'b1;
        l_d   = CNTW'(l_q + 1'b1);
        if (CNTW'(l_q + 1'b1) == cols_eff) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DIV_START;
      end
      ST_DIV_START: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          if (pair_last) begin
            state_d = ST_IDLE;
          end else begin
            j_d     = j_q + 1'b1;
            l_d     = '0;
            acc_clr = 1'b1;
            state_d = (cols_eff == '0) ? ST_DIV_START : ST_READ;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and read pipeline valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
    end
  end

  // Row and column pointers
  always_ff @(posedge clk_i) begin
    i_q <= i_d;
    j_q <= j_d;
    l_q <= l_d;
  end

  phj_ram #(
    .WIDTH (ALLELE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (waddr),
    .wdata_i   (ALLELE_BITS'(allele_code_i)),
    .re_i      (rd_en),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  phj_pair #(
    .ALLELE_BITS (ALLELE_BITS),
    .CNT_W       (CNTW)
  ) u_pair (
    .clk_i   (clk_i),
    .clear_i (acc_clr),
    .valid_i (rd_vld_q),
    .a_i     (rdata_a),
    .b_i     (rdata_b),
    .ham_o   (ham),
    .uni_o   (uni),
    .inter_o (inter)
  );

  phj_div #(
    .CNT_W (CNTW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (uni - inter),
    .den_i   (uni),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  // Output word valid: set on load, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output word payload; empty union gives zero distance
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      first_row_q  <= ROW_W'(i_q);
      second_row_q <= ROW_W'(j_q);
      ham_out_q    <= (32'(ham) > HAMMING_MAX) ? HAMMING_W'(HAMMING_MAX) : HAMMING_W'(ham);
      jac_out_q    <= (uni == '0) ? '0 : quot;
      last_q       <= pair_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign first_row_o     = first_row_q;
  assign second_row_o    = second_row_q;
  assign hamming_count_o = ham_out_q;
  assign jaccard_q16_o   = jac_out_q;
  assign last_of_sweep_o = last_q;

endmodule

// ===== sim/pairwise_hamming_jaccard_top_tb.sv =====
// Testbench for pairwise_hamming_jaccard_top: a directed table, directed phases, then randomized phases.
// Carries its own model of the allele matrix and the distance sweep; depends on phj_pkg.
module pairwise_hamming_jaccard_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import phj_pkg::*;

  localparam int N_ROWS       = MAX_ROWS_DEF;
  localparam int N_COLS       = MAX_COLUMNS_DEF;
  localparam int RESET_CYCLES = 12;
  localparam int IDLE_PCT     = 37;
  localparam int SETTLE_CYCLES = 32;
  localparam int HOLD_CYCLES  = 600;
  localparam int QUIET_LIMIT  = 8000;
  localparam int MAX_REPORTS  = 10;
  localparam logic [CODE_W-1:0] CODE_MASK = CODE_W'((1 << ALLELE_BITS_DEF) - 1);
  localparam logic [CODE_W-1:0] PRESENT   = 8'd1;

  // register indexes that decode to nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [ROW_W-1:0]     first_row;
    logic [ROW_W-1:0]     second_row;
    logic [HAMMING_W-1:0] hamming;
    logic [JAC_W-1:0]     jaccard;
    logic                 last;
  } pair_t;

  // how a directed row is checked
  typedef enum logic [1:0] {
    STEP_CFG,      // register write
    STEP_MODEL,    // word checked through the model
    STEP_NO_PAIR,  // sweep that must emit nothing
    STEP_ONE_PAIR  // sweep of row i with exactly the pair (i, i+1) given below
  } step_kind_e;

  // data: allele code for words, register value for register writes
  typedef struct packed {
    step_kind_e            kind;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic                  act;
    logic [ROW_W-1:0]      row;
    logic [COLUMN_W-1:0]   col;
    logic [CFG_DATA_W-1:0] data;
    logic [HAMMING_W-1:0]  hamming;
    logic [JAC_W-1:0]      jaccard;
  } step_t;

  localparam int N_STEPS = 25;
  step_t directed_steps [N_STEPS] = '{
    '{STEP_NO_PAIR,  CFG_ROW_COUNT,    ACT_SWEEP, 6'd0,  8'd0,   9'd0,   9'd0, 17'd0},
    '{STEP_CFG,      CFG_ROW_COUNT,    ACT_WRITE, 6'd0,  8'd0,   9'd2,   9'd0, 17'd0},
    '{STEP_CFG,      CFG_COLUMN_COUNT, ACT_WRITE, 6'd0,  8'd0,   9'd2,   9'd0, 17'd0},
    '{STEP_MODEL,    CFG_ROW_COUNT,    ACT_WRITE, 6'd0,  8'd0,   9'd1,   9'd0, 17'd0},
    '{STEP_MODEL,    CFG_ROW_COUNT,    ACT_WRITE, 6'd0,  8'd1,   9'd0,   9'd0, 17'd0},
    '{STEP_MODEL,    CFG_ROW_COUNT,    ACT_WRITE, 6'd1,  8'd0,   9'd1,   9'd0, 17'd0},
    '{STEP_MODEL,    CFG_ROW_COUNT,    ACT_WRITE, 6'd1,  8'd1,   9'd1,   9'd0, 17'd0},
    '{STEP_ONE_PAIR, CFG_ROW_COUNT,    ACT_SWEEP, 6'd0,  8'd255, 9'd255, 9'd1, 17'd32768},
    '{STEP_NO_PAIR,  CFG_ROW_COUNT,    ACT_SWEEP, 6'd1,  8'd0,   9'd0,   9'd0, 17'd0},
    '{STEP_NO_PAIR,  CFG_ROW_COUNT,    ACT_SWEEP, 6'd63, 8'd0,   9'd0,   9'd0, 17'd0},
    '{STEP_MODEL,    CFG_ROW_COUNT,    ACT_WRITE, 6'd1,  8'd0,   9'd2,   9'd0, 17'd0},
    '{STEP_MODEL,    CFG_ROW_COUNT,    ACT_WRITE, 6'd1,  8'd1,   9'd2,   9'd0, 17'd0},
    '{STEP_ONE_PAIR, CFG_ROW_COUNT,    ACT_SWEEP, 6'd0,  8'd0,   9'd0,   9'd2, 17'd65536},
    '{STEP_MODEL,    CFG_ROW_COUNT,    ACT_WRITE, 6'd0,  8'd0,   9'd0,   9'd0, 17'd0},
    '{STEP_ONE_PAIR, CFG_ROW_COUNT,    ACT_SWEEP, 6'd0,  8'd0,   9'd0,   9'd2, 17'd0},
    '{STEP_MODEL,    CFG_ROW_COUNT,    ACT_WRITE, 6'd63, 8'd255, 9'd255, 9'd0, 17'd0},
    '{STEP_CFG,      CFG_SPARE_A,      ACT_WRITE, 6'd0,  8'd0,   9'd511, 9'd0, 17'd0},
    '{STEP_CFG,      CFG_SPARE_B,      ACT_WRITE, 6'd0,  8'd0,   9'd0,   9'd0, 17'd0},
    '{STEP_ONE_PAIR, CFG_ROW_COUNT,    ACT_SWEEP, 6'd0,  8'd0,   9'd0,   9'd2, 17'd0},
    '{STEP_MODEL,    CFG_ROW_COUNT,    ACT_WRITE, 6'd0,  8'd0,   9'd2,   9'd0, 17'd0},
    '{STEP_MODEL,    CFG_ROW_COUNT,    ACT_WRITE, 6'd0,  8'd1,   9'd2,   9'd0, 17'd0},
    '{STEP_ONE_PAIR, CFG_ROW_COUNT,    ACT_SWEEP, 6'd0,  8'd0,   9'd0,   9'd0, 17'd0},
    '{STEP_CFG,      CFG_COLUMN_COUNT, ACT_WRITE, 6'd0,  8'd0,   9'd0,   9'd0, 17'd0},
    '{STEP_CFG,      CFG_ROW_COUNT,    ACT_WRITE, 6'd0,  8'd0,   9'd3,   9'd0, 17'd0},
    '{STEP_MODEL,    CFG_ROW_COUNT,    ACT_SWEEP, 6'd0,  8'd0,   9'd0,   9'd0, 17'd0}
  };

  logic                  clk_i;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_valid_i    = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic                  action_i       = ACT_WRITE;
  logic [ROW_W-1:0]      row_index_i    = '0;
  logic [COLUMN_W-1:0]   column_index_i = '0;
  logic [CODE_W-1:0]     allele_code_i  = '0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic [ROW_W-1:0]      first_row_o;
  logic [ROW_W-1:0]      second_row_o;
  logic [HAMMING_W-1:0]  hamming_count_o;
  logic [JAC_W-1:0]      jaccard_q16_o;
  logic                  last_of_sweep_o;

  // model state: matrix mirror, register mirror and pairs still to come
  logic [CODE_W-1:0] allele_mirror [N_ROWS][N_COLS];
  bit                cell_written  [N_ROWS][N_COLS];
  int unsigned       rows_in_use = 0;
  int unsigned       cols_in_use = 0;
  pair_t             pairs_due [$];

  int unsigned words_sent    = 0;
  int unsigned failures      = 0;
  bit          calm          = 1'b0;
  bit          hold_pending  = 1'b0;

  pairwise_hamming_jaccard_top u_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Queue every pair that a sweep of row i yields under the current registers
  function automatic void sweep_distances(input logic [ROW_W-1:0] row);
    pair_t             p;
    int unsigned       ham, uni, both;
    logic [CODE_W-1:0] a, b;
    longint unsigned   jac_val;
    for (int unsigned j = row + 1; j < rows_in_use; j++) begin
      ham  = 0;
      uni  = 0;
      both = 0;
      for (int unsigned c = 0; c < cols_in_use; c++) begin
        a = allele_mirror[row][c];
        b = allele_mirror[j][c];
        if (a != b) ham++;
        if (a == PRESENT || b == PRESENT) begin
          uni++;
          if (a == PRESENT && b == PRESENT) both++;
        end
      end
      jac_val = 0;
      if (uni != 0) begin
        jac_val = uni - both;
        jac_val = (jac_val << 16) / uni;
      end
      p.first_row  = row;
      p.second_row = j[ROW_W-1:0];
      p.hamming    = (ham > HAMMING_MAX) ? HAMMING_W'(HAMMING_MAX) : ham[HAMMING_W-1:0];
      p.jaccard    = jac_val[JAC_W-1:0];
      p.last       = (j + 1 == rows_in_use);
      pairs_due.push_back(p);
    end
  endfunction

  // Update the model for one accepted input word
  function automatic void track_word(input logic act, input logic [ROW_W-1:0] row,
                                     input logic [COLUMN_W-1:0] col,
                                     input logic [CODE_W-1:0] code);
    if (act == ACT_WRITE) begin
      allele_mirror[row][col] = code & CODE_MASK;
      cell_written[row][col]  = 1'b1;
    end else begin
      sweep_distances(row);
    end
  endfunction

  // Mirror one register write, saturating at the store size
  function automatic void track_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_ROW_COUNT: begin
        rows_in_use = (data[ROW_CNT_W-1:0] > N_ROWS) ? N_ROWS : data[ROW_CNT_W-1:0];
      end
      CFG_COLUMN_COUNT: begin
        cols_in_use = (data[COL_CNT_W-1:0] > N_COLS) ? N_COLS : data[COL_CNT_W-1:0];
      end
      default: ;
    endcase
  endfunction

  // Mostly presence and absence codes so that Jaccard sees real overlap
  function automatic logic [CODE_W-1:0] random_code();
    int unsigned pick = $urandom_range(99);
    if (pick < 35) return PRESENT;
    if (pick < 60) return '0;
    if (pick < 75) return 8'd2;
    return CODE_W'($urandom_range(255));
  endfunction

  // Offer one input word and hold it until accepted; valid stays high afterwards
  task automatic offer_word(input logic act, input logic [ROW_W-1:0] row,
                            input logic [COLUMN_W-1:0] col, input logic [CODE_W-1:0] code,
                            input bit modeled);
    cfg_valid_i <= 1'b0;
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    row_index_i    <= row;
    column_index_i <= col;
    allele_code_i  <= code;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
    if (modeled) track_word(act, row, col, code);
  endtask

  // Write one register; valid stays high until the next word lowers it
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    track_register(idx, data);
  endtask

  // Wait for every pending pair, then let a sweep with no pairs finish
  task automatic drain_pairs();
    in_valid_i <= 1'b0;
    while (pairs_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] rows, input logic [CFG_DATA_W-1:0] cols);
    drain_pairs();
    write_register(CFG_ROW_COUNT, rows);
    write_register(CFG_COLUMN_COUNT, cols);
  endtask

  // Sweep a row after writing every cell the sweep will read
  task automatic sweep_row(input logic [ROW_W-1:0] row);
    if (row + 1 < rows_in_use) begin
      for (int unsigned r = row; r < rows_in_use; r++)
        for (int unsigned c = 0; c < cols_in_use; c++)
          if (!cell_written[r][c])
            offer_word(ACT_WRITE, r[ROW_W-1:0], c[COLUMN_W-1:0], random_code(), 1'b1);
    end
    offer_word(ACT_SWEEP, row, COLUMN_W'($urandom_range(255)), CODE_W'($urandom_range(255)),
               1'b1);
  endtask

  // Random mix of sweeps and cell writes under the current registers
  task automatic scramble(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(99) < 40) begin
        if (rows_in_use >= 2 && $urandom_range(9) != 0)
          sweep_row(ROW_W'($urandom_range(rows_in_use - 1)));
        else
          sweep_row(ROW_W'($urandom_range(N_ROWS - 1)));
      end else if (rows_in_use != 0 && cols_in_use != 0 && $urandom_range(9) < 7) begin
        offer_word(ACT_WRITE, ROW_W'($urandom_range(rows_in_use - 1)),
                   COLUMN_W'($urandom_range(cols_in_use - 1)), random_code(), 1'b1);
      end else begin
        offer_word(ACT_WRITE, ROW_W'($urandom_range(N_ROWS - 1)),
                   COLUMN_W'($urandom_range(N_COLS - 1)), random_code(), 1'b1);
      end
    end
  endtask

  function automatic void flag_pair(input string what, input pair_t want, input pair_t got);
    failures++;
    if (failures <= MAX_REPORTS)
      $display("%s: expected %0d/%0d ham %0d jac %0d last %0b, got %0d/%0d ham %0d jac %0d last %0b",
               what, want.first_row, want.second_row, want.hamming, want.jaccard, want.last,
               got.first_row, got.second_row, got.hamming, got.jaccard, got.last);
  endfunction

  // Receiver pacing: random stalls, one long hold-off on request
  initial begin : sink_pacing
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall_i <= 1'b1;
        for (int held = 0; held < HOLD_CYCLES; held++) @(posedge clk_i);
      end
      out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Compare each accepted pair with the oldest pending one
  initial begin : pair_checker
    pair_t got, want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got = '{first_row_o, second_row_o, hamming_count_o, jaccard_q16_o, last_of_sweep_o};
        if (pairs_due.size() == 0) begin
          flag_pair("pair with nothing pending", '0, got);
        end else begin
          want = pairs_due.pop_front();
          if (got.first_row !== want.first_row || got.second_row !== want.second_row ||
              got.hamming !== want.hamming || got.jaccard !== want.jaccard ||
              got.last !== want.last)
            flag_pair("pair mismatch", want, got);
        end
      end
    end
  end

  // End the run when no channel moves a word for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    step_t       step;
    pair_t       typed;
    bit          prev_cfg;
    int unsigned random_start;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    prev_cfg = 1'b1;
    foreach (directed_steps[k]) begin
      step = directed_steps[k];
      if (step.kind == STEP_CFG) begin
        if (!prev_cfg) drain_pairs();
        write_register(step.reg_index, step.data);
        prev_cfg = 1'b1;
      end else begin
        offer_word(step.act, step.row, step.col, step.data[CODE_W-1:0], step.kind == STEP_MODEL);
        if (step.kind == STEP_ONE_PAIR) begin
          typed.first_row  = step.row;
          typed.second_row = step.row + 6'd1;
          typed.hamming    = step.hamming;
          typed.jaccard    = step.jaccard;
          typed.last       = 1'b1;
          pairs_due.push_back(typed);
        end
        prev_cfg = 1'b0;
      end
    end

    // All rows in use on a few columns, no idling on either side
    calm = 1'b1;
    configure(9'd64, 9'd8);
    sweep_row(6'd62);
    sweep_row(6'd63);
    calm = 1'b0;

    // Row count past the store size saturates
    configure(9'd127, 9'd8);
    sweep_row(6'd62);
    offer_word(ACT_WRITE, 6'd62, 8'd128, random_code(), 1'b1);
    sweep_row(6'd62);

    // Zero columns: a full sweep of row 0 first, receiver holds off while sweeps keep coming
    configure(9'd64, 9'd0);
    hold_pending = 1'b1;
    sweep_row(6'd0);
    sweep_row(6'd1);
    sweep_row(6'd40);
    sweep_row(6'd63);

    // No rows, then a single row: sweeps emit nothing
    configure(9'd0, 9'd5);
    sweep_row(6'd0);
    configure(9'd1, 9'd3);
    sweep_row(6'd0);

    // Random phases on small matrices
    random_start = words_sent;
    while (words_sent - random_start < 50) begin
      configure(CFG_DATA_W'($urandom_range(2, 7)),
                ($urandom_range(99) < 10) ? '0 : CFG_DATA_W'($urandom_range(1, 10)));
      scramble(12);
    end

    drain_pairs();
    if (failures == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
